// ----- rtl/core/absv_pkg.sv -----
// Shared types, constants and the CRC step function for the slot validator.
`default_nettype none
package absv_pkg;

  // Slot geometry and header layout (byte offsets within a slot).
  localparam int SLOT_BYTES = 5120;
  localparam int POS_W      = $clog2(SLOT_BYTES);
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_VERSION = pos_t'(4);
  localparam pos_t POS_COUNT   = pos_t'(6);
  localparam pos_t POS_SEQ     = pos_t'(8);
  localparam pos_t POS_GEN     = pos_t'(12);
  localparam pos_t POS_HDR_END = pos_t'(14);
  localparam pos_t POS_CRC_END = pos_t'(SLOT_BYTES - 4);
  localparam pos_t POS_LAST    = pos_t'(SLOT_BYTES - 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Event queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam logic [31:0] MAGIC_RESET       = 32'h4754_4F43;
  localparam logic [15:0] MAX_VERSION_RESET = 16'd1;
  localparam logic [9:0]  MAX_ENTRIES_RESET = 10'd512;

  typedef enum logic [1:0] {
    REG_MAGIC       = 2'd0,
    REG_MAX_VERSION = 2'd1,
    REG_MAX_ENTRIES = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_MARK    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    EV_RESTART = 2'd0,
    EV_MARK    = 2'd1,
    EV_SLOT    = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [15:0] max_version;
    logic [9:0]  max_entries;
  } cfg_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic        sidx;
    logic        valid;
    logic [31:0] seq;
    logic [15:0] count;
    logic [15:0] gen;
  } ev_t;

  typedef struct packed {
    logic        slot_valid;
    logic [31:0] slot_seq;
    logic [15:0] slot_count;
    logic [15:0] slot_gen;
    logic        became_best;
    logic        have_valid;
    logic        best_slot;
    logic [31:0] best_seq;
    logic        store_writable;
    logic        next_write_slot;
  } res_t;

  // One byte of the reflected CRC-32, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/absv_front.sv -----
// Front part: takes words, captures header fields, runs the CRC, queues events.
`default_nettype none
module absv_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire absv_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     cmd,
  input  wire logic [7:0]     data_byte,
  input  wire logic           slot_index,
  input  wire logic           q_full,
  output logic                q_push,
  output absv_pkg::ev_t       q_data
);

  absv_pkg::pos_t pos;
  logic [31:0]    crc;
  logic [31:0]    hdr_magic;
  logic [15:0]    hdr_version;
  logic [15:0]    hdr_count;
  logic [31:0]    hdr_seq;
  logic [15:0]    hdr_gen;
  logic [31:0]    stored_crc;

  logic        accept;
  logic        is_last;
  logic [31:0] stored_crc_next;
  logic        hdr_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_last  = (pos == absv_pkg::POS_LAST);

  assign stored_crc_next = {data_byte, stored_crc[31:8]};

  // All header bytes and the CRC are final by the last byte of the slot.
  assign hdr_ok = (hdr_magic == cfg.magic_word) &&
                  (hdr_version != 16'd0) &&
                  (hdr_version <= cfg.max_version) &&
                  (hdr_count <= {6'd0, cfg.max_entries}) &&
                  ((crc ^ absv_pkg::CRC_INIT) == stored_crc_next);

  always_comb begin
    q_push        = 1'b0;
    q_data.kind   = absv_pkg::EV_SLOT;
    q_data.sidx   = slot_index;
    q_data.valid  = hdr_ok;
    q_data.seq    = hdr_seq;
    q_data.count  = hdr_count;
    q_data.gen    = hdr_gen;
    unique case (cmd)
      absv_pkg::CMD_RESTART: begin
        q_push      = accept;
        q_data.kind = absv_pkg::EV_RESTART;
      end
      absv_pkg::CMD_MARK: begin
        q_push      = accept;
        q_data.kind = absv_pkg::EV_MARK;
      end
      absv_pkg::CMD_BYTE: begin
        q_push = accept && is_last;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= absv_pkg::CRC_INIT;
    end else if (accept) begin
      unique case (cmd)
        absv_pkg::CMD_RESTART, absv_pkg::CMD_MARK: begin
          pos <= '0;
          crc <= absv_pkg::CRC_INIT;
        end
        absv_pkg::CMD_BYTE: begin
          if (is_last) begin
            pos <= '0;
            crc <= absv_pkg::CRC_INIT;
          end else begin
            pos <= pos + absv_pkg::pos_t'(1);
            if (pos < absv_pkg::POS_CRC_END) begin
              crc <= absv_pkg::crc_byte(crc, data_byte);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Header and stored CRC bytes are fully rewritten in every slot before use.
  always_ff @(posedge clk) begin
    if (accept && (cmd == absv_pkg::CMD_BYTE)) begin
      if (pos < absv_pkg::POS_VERSION) begin
        hdr_magic <= {data_byte, hdr_magic[31:8]};
      end else if (pos < absv_pkg::POS_COUNT) begin
        hdr_version <= {data_byte, hdr_version[15:8]};
      end else if (pos < absv_pkg::POS_SEQ) begin
        hdr_count <= {data_byte, hdr_count[15:8]};
      end else if (pos < absv_pkg::POS_GEN) begin
        hdr_seq <= {data_byte, hdr_seq[31:8]};
      end else if (pos < absv_pkg::POS_HDR_END) begin
        hdr_gen <= {data_byte, hdr_gen[15:8]};
      end
      if (pos >= absv_pkg::POS_CRC_END) begin
        stored_crc <= stored_crc_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/absv_queue.sv -----
// Short event queue in flops between the front and back parts.
`default_nettype none
module absv_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire absv_pkg::ev_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output absv_pkg::ev_t      head
);

  absv_pkg::ev_t                entries [absv_pkg::QDEPTH];
  logic [absv_pkg::QPTR_W-1:0]  wr_ptr;
  logic [absv_pkg::QPTR_W-1:0]  rd_ptr;
  logic [absv_pkg::QCNT_W-1:0]  fill;

  assign full      = (fill == absv_pkg::QCNT_W'(absv_pkg::QDEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + absv_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + absv_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + absv_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - absv_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/absv_back.sv -----
// Back part: applies queued events to the A/B selection and registers results.
`default_nettype none
module absv_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_not_empty,
  input  wire absv_pkg::ev_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output absv_pkg::res_t     res
);

  logic [31:0] newest_seq;
  logic        newest_slot;
  logic        any_valid;
  logic        any_unreadable;

  logic [31:0] newest_seq_next;
  logic        newest_slot_next;
  logic        any_valid_next;
  logic        any_unreadable_next;

  logic        out_free;
  logic        is_slot;
  logic [31:0] seq_diff;
  logic        is_newer;
  logic        best;
  absv_pkg::res_t res_next;

  assign out_free = !out_valid || !out_stall;
  assign is_slot  = (q_head.kind == absv_pkg::EV_SLOT);
  // Events that produce no word never wait on the output side.
  assign q_pop    = q_not_empty && (!is_slot || out_free);

  // Wrapping order: newer when the difference is nonzero and below half range.
  assign seq_diff = q_head.seq - newest_seq;
  assign is_newer = (seq_diff != 32'd0) && !seq_diff[31];
  assign best     = q_head.valid && (!any_valid || is_newer);

  always_comb begin
    newest_seq_next     = newest_seq;
    newest_slot_next    = newest_slot;
    any_valid_next      = any_valid;
    any_unreadable_next = any_unreadable;
    unique case (q_head.kind)
      absv_pkg::EV_RESTART: begin
        newest_seq_next     = 32'd0;
        newest_slot_next    = 1'b0;
        any_valid_next      = 1'b0;
        any_unreadable_next = 1'b0;
      end
      absv_pkg::EV_MARK: begin
        any_unreadable_next = 1'b1;
      end
      absv_pkg::EV_SLOT: begin
        if (best) begin
          newest_seq_next  = q_head.seq;
          newest_slot_next = q_head.sidx;
          any_valid_next   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_next.slot_valid      = q_head.valid;
    res_next.slot_seq        = q_head.seq;
    res_next.slot_count      = q_head.count;
    res_next.slot_gen        = q_head.gen;
    res_next.became_best     = best;
    res_next.have_valid      = any_valid_next;
    res_next.best_slot       = newest_slot_next;
    res_next.best_seq        = newest_seq_next;
    res_next.store_writable  = any_valid_next || !any_unreadable_next;
    res_next.next_write_slot = any_valid_next && !newest_slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_seq     <= 32'd0;
      newest_slot    <= 1'b0;
      any_valid      <= 1'b0;
      any_unreadable <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        newest_seq     <= newest_seq_next;
        newest_slot    <= newest_slot_next;
        any_valid      <= any_valid_next;
        any_unreadable <= any_unreadable_next;
      end
      if (q_pop && is_slot) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_slot) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ab_slot_validator_selector.sv -----
// Top level of the record slot validator and A/B slot selector.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------------
//   input    | in_valid / in_stall     | cmd, data_byte, slot_index
//   output   | out_valid / out_stall   | slot_valid .. next_write_slot (one word/slot)
//   config   | APB psel/penable/pwrite | paddr, pwdata, prdata (magic, version, count)
//
// One input word is taken per cycle while in_stall is low; each word updates the front part
// (header capture and one byte of CRC), and a slot's summary is pushed with its last byte into a
// four-entry queue, then registered into the output register once that register is free.
// Input stalls only when that queue is full; the output register frees as soon as
// its word is taken. Reset is synchronous and clears the selection, the byte
// counter and the CRC; configuration returns to its reset values.
`default_nettype none
module ab_slot_validator_selector (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [absv_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   cmd,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         slot_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              slot_valid,
  output logic [31:0]                       slot_seq,
  output logic [15:0]                       slot_count,
  output logic [15:0]                       slot_gen,
  output logic                              became_best,
  output logic                              have_valid,
  output logic                              best_slot,
  output logic [31:0]                       best_seq,
  output logic                              store_writable,
  output logic                              next_write_slot
);

  absv_pkg::cfg_t cfg;
  absv_pkg::ev_t  q_in;
  absv_pkg::ev_t  q_head;
  absv_pkg::res_t res;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_not_empty;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word  <= absv_pkg::MAGIC_RESET;
      cfg.max_version <= absv_pkg::MAX_VERSION_RESET;
      cfg.max_entries <= absv_pkg::MAX_ENTRIES_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        absv_pkg::REG_MAGIC:       cfg.magic_word  <= pwdata;
        absv_pkg::REG_MAX_VERSION: cfg.max_version <= pwdata[15:0];
        absv_pkg::REG_MAX_ENTRIES: cfg.max_entries <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      absv_pkg::REG_MAGIC:       prdata = cfg.magic_word;
      absv_pkg::REG_MAX_VERSION: prdata = {16'd0, cfg.max_version};
      absv_pkg::REG_MAX_ENTRIES: prdata = {22'd0, cfg.max_entries};
      default:                   prdata = 32'd0;
    endcase
  end

  absv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .slot_index (slot_index),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  absv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  absv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign slot_valid      = res.slot_valid;
  assign slot_seq        = res.slot_seq;
  assign slot_count      = res.slot_count;
  assign slot_gen        = res.slot_gen;
  assign became_best     = res.became_best;
  assign have_valid      = res.have_valid;
  assign best_slot       = res.best_slot;
  assign best_seq        = res.best_seq;
  assign store_writable  = res.store_writable;
  assign next_write_slot = res.next_write_slot;

endmodule
`default_nettype wire

// ----- verif/absv_checker.sv -----
// Checker for the slot validator: predicts each slot summary word and compares it with the output.
`timescale 1ns / 1ps
module absv_checker
  import absv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [7:0]         data_byte,
  input  logic               slot_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  res_t               out_word,
  output int                 mismatches,
  output int                 pending_results
);

  // Register copies, as snooped from the configuration port.
  logic [31:0] want_magic;
  logic [15:0] want_max_ver;
  logic [9:0]  want_max_cnt;

  // Slot being streamed in.
  pos_t        pos;
  logic [31:0] crc_run;
  logic [31:0] got_magic;
  logic [15:0] got_ver;
  logic [15:0] got_cnt;
  logic [31:0] got_seq;
  logic [15:0] got_gen;
  logic [31:0] tail_crc;

  // Selection since the last restart.
  logic [31:0] newest;
  logic        newest_idx;
  logic        seen_valid;
  logic        seen_unreadable;

  res_t summaries[$];
  int   fails = 0;
  int   waiting = 0;

  assign mismatches      = fails;
  assign pending_results = waiting;

  // Reflected CRC-32, one data bit at a time.
  function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  // a is ahead of b when the wrapped difference is nonzero and below half the range.
  function automatic logic seq_ahead(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  task automatic restart_slot();
    pos       = '0;
    crc_run   = CRC_INIT;
    got_magic = '0;
    got_ver   = '0;
    got_cnt   = '0;
    got_seq   = '0;
    got_gen   = '0;
    tail_crc  = '0;
  endtask

  task automatic clear_selection();
    newest          = '0;
    newest_idx      = 1'b0;
    seen_valid      = 1'b0;
    seen_unreadable = 1'b0;
  endtask

  task automatic finish_slot(input logic idx);
    res_t summary;
    logic ok;
    logic took;
    ok = (got_magic == want_magic) && (got_ver != 16'd0) && (got_ver <= want_max_ver) &&
         (got_cnt <= {6'd0, want_max_cnt}) && ((~crc_run) == tail_crc);
    took = ok && (!seen_valid || seq_ahead(got_seq, newest));
    if (took) begin
      seen_valid = 1'b1;
      newest     = got_seq;
      newest_idx = idx;
    end
    summary.slot_valid      = ok;
    summary.slot_seq        = got_seq;
    summary.slot_count      = got_cnt;
    summary.slot_gen        = got_gen;
    summary.became_best     = took;
    summary.have_valid      = seen_valid;
    summary.best_slot       = newest_idx;
    summary.best_seq        = newest;
    summary.store_writable  = !(!seen_valid && seen_unreadable);
    summary.next_write_slot = seen_valid ? ~newest_idx : 1'b0;
    summaries.push_back(summary);
    restart_slot();
  endtask

  task automatic take_byte(input logic [7:0] b, input logic idx);
    // Header fields are little-endian, so each new byte enters at the top.
    if (pos < POS_VERSION) got_magic = {b, got_magic[31:8]};
    else if (pos < POS_COUNT) got_ver = {b, got_ver[15:8]};
    else if (pos < POS_SEQ) got_cnt = {b, got_cnt[15:8]};
    else if (pos < POS_GEN) got_seq = {b, got_seq[31:8]};
    else if (pos < POS_HDR_END) got_gen = {b, got_gen[15:8]};
    if (pos < POS_CRC_END) crc_run = crc_fold(crc_run, b);
    else tail_crc = {b, tail_crc[31:8]};
    if (pos == POS_LAST) finish_slot(idx);
    else pos++;
  endtask

  task automatic flag(input string field, input logic [31:0] want_v, input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
    fails++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      want_magic   = MAGIC_RESET;
      want_max_ver = MAX_VERSION_RESET;
      want_max_cnt = MAX_ENTRIES_RESET;
      restart_slot();
      clear_selection();
      summaries.delete();
    end else begin
      // Outputs are checked before inputs so a word never matches a summary queued this edge.
      if (out_valid && !out_stall) begin
        if (summaries.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual seq %h valid %b",
                   $time, out_word.slot_seq, out_word.slot_valid);
          fails++;
        end else begin
          want = summaries.pop_front();
          if (out_word.slot_valid !== want.slot_valid)
            flag("slot_valid", 32'(want.slot_valid), 32'(out_word.slot_valid));
          if (out_word.slot_seq !== want.slot_seq)
            flag("slot_seq", want.slot_seq, out_word.slot_seq);
          if (out_word.slot_count !== want.slot_count)
            flag("slot_count", 32'(want.slot_count), 32'(out_word.slot_count));
          if (out_word.slot_gen !== want.slot_gen)
            flag("slot_gen", 32'(want.slot_gen), 32'(out_word.slot_gen));
          if (out_word.became_best !== want.became_best)
            flag("became_best", 32'(want.became_best), 32'(out_word.became_best));
          if (out_word.have_valid !== want.have_valid)
            flag("have_valid", 32'(want.have_valid), 32'(out_word.have_valid));
          if (out_word.best_slot !== want.best_slot)
            flag("best_slot", 32'(want.best_slot), 32'(out_word.best_slot));
          if (out_word.best_seq !== want.best_seq)
            flag("best_seq", want.best_seq, out_word.best_seq);
          if (out_word.store_writable !== want.store_writable)
            flag("store_writable", 32'(want.store_writable), 32'(out_word.store_writable));
          if (out_word.next_write_slot !== want.next_write_slot)
            flag("next_write_slot", 32'(want.next_write_slot),
                 32'(out_word.next_write_slot));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_MAGIC:       want_magic   = pwdata;
          REG_MAX_VERSION: want_max_ver = pwdata[15:0];
          REG_MAX_ENTRIES: want_max_cnt = pwdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (cmd)
          CMD_RESTART: begin
            restart_slot();
            clear_selection();
          end
          CMD_MARK: begin
            seen_unreadable = 1'b1;
            restart_slot();
          end
          CMD_BYTE: take_byte(data_byte, slot_index);
          default: ;
        endcase
      end
    end
    waiting = summaries.size();
  end

endmodule

// ----- verif/tb_ab_slot_validator_selector.sv -----
// Testbench top for the slot validator: drives slot streams, register writes and handshakes.
`timescale 1ns / 1ps
module tb_ab_slot_validator_selector;
  import absv_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NEVER          = SLOT_BYTES;
  localparam int HOLD_CYCLES    = 12000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int DRAIN_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT = 50000;

  // One slot to stream; cut_at and junk_at equal NEVER when unused.
  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] count;
    logic [31:0] seq;
    logic [15:0] gen;
    logic        bad_crc;
    logic        last_idx;
    int          cut_at;
    logic [1:0]  cut_cmd;
    int          junk_at;
  } slot_plan_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = CMD_RESTART;
  logic [7:0]         data_byte = '0;
  logic               slot_index = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               slot_valid;
  logic [31:0]        slot_seq;
  logic [15:0]        slot_count;
  logic [15:0]        slot_gen;
  logic               became_best;
  logic               have_valid;
  logic               best_slot;
  logic [31:0]        best_seq;
  logic               store_writable;
  logic               next_write_slot;
  res_t               out_word;

  int mismatches;
  int pending_results;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_go = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  logic [31:0] cur_magic = MAGIC_RESET;
  logic [15:0] cur_max_ver = MAX_VERSION_RESET;
  logic [9:0]  cur_max_cnt = MAX_ENTRIES_RESET;
  logic [31:0] recent_seq = '0;

  always #1 clk = ~clk;

  assign out_word = {slot_valid, slot_seq, slot_count, slot_gen, became_best, have_valid,
                     best_slot, best_seq, store_writable, next_write_slot};

  ab_slot_validator_selector u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .data_byte(data_byte), .slot_index(slot_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot_valid(slot_valid), .slot_seq(slot_seq), .slot_count(slot_count),
    .slot_gen(slot_gen), .became_best(became_best), .have_valid(have_valid),
    .best_slot(best_slot), .best_seq(best_seq), .store_writable(store_writable),
    .next_write_slot(next_write_slot)
  );

  absv_checker u_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .data_byte(data_byte), .slot_index(slot_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .mismatches(mismatches), .pending_results(pending_results)
  );

  // Result receiver; a bump of hold_go starts a long hold-off counted here.
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else out_stall = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] crc_next(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Entered and left at a falling edge; the word stays offered until accepted.
  task automatic send_word(input logic [1:0] c, input logic [7:0] b, input logic idx);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = c;
    data_byte  = b;
    slot_index = idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_slot(input slot_plan_t sp);
    logic [111:0] hdr;
    logic [31:0]  crc;
    logic [31:0]  tail;
    logic [7:0]   b;
    logic         idx;
    hdr  = {sp.gen, sp.seq, sp.count, sp.version, sp.magic};
    crc  = CRC_INIT;
    tail = '0;
    for (int p = 0; p < SLOT_BYTES; p++) begin
      if (p == sp.cut_at) begin
        send_word(sp.cut_cmd, 8'($urandom), 1'($urandom));
        return;
      end
      if (p == sp.junk_at) send_word(CMD_UNUSED, 8'($urandom), 1'($urandom));
      if (p == int'(POS_CRC_END))
        tail = ~crc ^ (sp.bad_crc ? (32'd1 << $urandom_range(31)) : 32'd0);
      if (p < int'(POS_HDR_END)) b = hdr[8*p +: 8];
      else if (p < int'(POS_CRC_END)) b = 8'($urandom);
      else b = tail[8*(p - int'(POS_CRC_END)) +: 8];
      if (p < int'(POS_CRC_END)) crc = crc_next(crc, b);
      idx = (p == int'(POS_LAST)) ? sp.last_idx : 1'($urandom);
      send_word(CMD_BYTE, b, idx);
    end
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    case (r)
      REG_MAGIC:       cur_magic   = v;
      REG_MAX_VERSION: cur_max_ver = v[15:0];
      REG_MAX_ENTRIES: cur_max_cnt = v[9:0];
      default: ;
    endcase
  endtask

  // Stop offering words until every slot summary has come out, then let the block settle.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] magic, input logic [31:0] max_ver,
                           input logic [31:0] max_cnt);
    send_gap_pct = 0;
    stall_pct    = 0;
    drain_results();
    write_reg(REG_MAGIC, magic);
    write_reg(REG_MAX_VERSION, max_ver);
    write_reg(REG_MAX_ENTRIES, max_cnt);
  endtask

  function automatic slot_plan_t clean_plan(input logic [31:0] seq, input logic idx);
    slot_plan_t sp;
    sp.magic    = cur_magic;
    sp.version  = 16'($urandom_range(cur_max_ver, 1));
    sp.count    = 16'($urandom_range(cur_max_cnt, 0));
    sp.seq      = seq;
    sp.gen      = 16'($urandom);
    sp.bad_crc  = 1'b0;
    sp.last_idx = idx;
    sp.cut_at   = NEVER;
    sp.cut_cmd  = CMD_MARK;
    sp.junk_at  = NEVER;
    return sp;
  endfunction

  // Mostly well-formed slots whose sequence numbers sit close to the last one,
  // with one flawed field in some and a dropped stream in a few.
  function automatic slot_plan_t random_plan();
    slot_plan_t  sp;
    logic [31:0] seq;
    case ($urandom_range(9))
      6: seq = recent_seq + 32'h8000_0000;
      7: seq = recent_seq + 32'h7FFF_FFFF;
      8: seq = recent_seq - 32'h7FFF_FFFF;
      9: seq = $urandom;
      default: seq = recent_seq + $urandom_range(6) - 3;
    endcase
    recent_seq = seq;
    sp = clean_plan(seq, 1'($urandom));
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0: sp.magic = cur_magic ^ (32'd1 << $urandom_range(31));
        1: sp.version = (cur_max_ver == 16'hFFFF || $urandom_range(1) == 0) ?
                        16'd0 : 16'($urandom_range(16'hFFFF, cur_max_ver + 1));
        2: sp.count = 16'($urandom_range(16'hFFFF, cur_max_cnt + 1));
        default: sp.bad_crc = 1'b1;
      endcase
    end
    if ($urandom_range(99) < 10) sp.junk_at = $urandom_range(SLOT_BYTES - 1);
    if ($urandom_range(99) < 12) begin
      sp.cut_at  = $urandom_range(SLOT_BYTES - 1);
      sp.cut_cmd = $urandom_range(1) ? CMD_MARK : CMD_RESTART;
    end
    return sp;
  endfunction

  task automatic run_random(input int slots);
    slot_plan_t sp;
    int         finished;
    int         c;
    finished = 0;
    while (finished < slots) begin
      if ($urandom_range(9) == 0) begin
        c = $urandom_range(9);
        send_word(c < 4 ? CMD_MARK : (c < 7 ? CMD_UNUSED : CMD_RESTART),
                  8'($urandom), 1'($urandom));
      end else begin
        sp = random_plan();
        send_slot(sp);
        if (sp.cut_at == NEVER) finished++;
      end
    end
  endtask

  initial begin
    slot_plan_t sp;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed slots under the reset register values.
    send_word(CMD_UNUSED, 8'hFF, 1'b1);
    send_word(CMD_MARK, 8'h00, 1'b1);
    send_word(CMD_RESTART, 8'hFF, 1'b0);
    sp = clean_plan(32'd5, 1'b0); sp.count = 16'd512; send_slot(sp);
    sp = clean_plan(32'd5, 1'b1); sp.count = 16'd513; send_slot(sp);
    sp = clean_plan(32'd6, 1'b0); sp.version = 16'd0; send_slot(sp);
    sp = clean_plan(32'd7, 1'b1); sp.version = 16'd2; send_slot(sp);
    sp = clean_plan(32'd8, 1'b1); sp.bad_crc = 1'b1; send_slot(sp);
    sp = clean_plan(32'd9, 1'b1); sp.magic = ~MAGIC_RESET; send_slot(sp);
    // Equal, older and exactly half-way sequences must not replace the best slot; just under half-way does.
    sp = clean_plan(32'd5, 1'b1); send_slot(sp);
    sp = clean_plan(32'd4, 1'b1); send_slot(sp);
    sp = clean_plan(32'h8000_0005, 1'b1); send_slot(sp);
    sp = clean_plan(32'h8000_0004, 1'b1); sp.junk_at = 17; send_slot(sp);
    sp = clean_plan(32'hFFFF_FFFF, 1'b0); sp.gen = 16'hFFFF; sp.count = 16'd0; send_slot(sp);
    sp = clean_plan(32'd3, 1'b1); sp.cut_at = 100; sp.cut_cmd = CMD_MARK; send_slot(sp);
    sp = clean_plan(32'd3, 1'b1); sp.gen = 16'd0; send_slot(sp);
    // Nothing valid after a restart and an unreadable mark: storage is not writable.
    send_word(CMD_RESTART, 8'h00, 1'b1);
    send_word(CMD_MARK, 8'h00, 1'b0);
    sp = clean_plan(32'hFFFF_FFFF, 1'b1);
    sp.magic = 32'hFFFF_FFFF; sp.version = 16'hFFFF; sp.count = 16'hFFFF;
    sp.gen = 16'hFFFF; sp.bad_crc = 1'b1;
    send_slot(sp);
    sp = clean_plan(32'd0, 1'b0); sp.cut_at = int'(POS_LAST); sp.cut_cmd = CMD_RESTART;
    send_slot(sp);
    sp = clean_plan(32'd0, 1'b1); send_slot(sp);

    configure(32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_FC00);
    run_random(14);

    configure(32'hFFFF_FFFF, 32'h5A5A_0001, 32'h0000_03FF);
    send_gap_pct = 83;
    run_random(4);

    configure($urandom, $urandom_range(16'hFFFF, 1), $urandom_range(1023));
    stall_pct = 83;
    run_random(12);

    // Hold results back while two slots and a burst of control words fill the block.
    configure(MAGIC_RESET, 32'd3, 32'd512);
    hold_go++;
    sp = clean_plan(recent_seq + 1, 1'b0); send_slot(sp);
    sp = clean_plan(recent_seq + 2, 1'b1); send_slot(sp);
    for (int i = 0; i < 12; i++)
      send_word(i % 3 == 0 ? CMD_RESTART : (i % 3 == 1 ? CMD_MARK : CMD_UNUSED),
                8'($urandom), 1'($urandom));
    drain_results();

    send_gap_pct = 34;
    stall_pct    = 34;
    run_random(10);

    send_gap_pct = 0;
    stall_pct    = 0;
    in_valid     = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
